[design/gzs_pkg.sv]
package gzs_pkg;

   // parameter defaults
   localparam int MAX_ZONES_ACROSS_DEF = 16;
   localparam int MAX_ZONES_DOWN_DEF   = 16;

   // input modes
   localparam logic [1:0] MODE_BEGIN  = 2'd0;
   localparam logic [1:0] MODE_MOTION = 2'd1;
   localparam logic [1:0] MODE_TOGGLE = 2'd2;
   localparam logic [1:0] MODE_END    = 2'd3;

   // register indexes
   localparam logic [2:0] REG_ZONES_ACROSS  = 3'd0;
   localparam logic [2:0] REG_ZONES_DOWN    = 3'd1;
   localparam logic [2:0] REG_INNER_PADDING = 3'd2;
   localparam logic [2:0] REG_LEEWAY_X      = 3'd3;
   localparam logic [2:0] REG_LEEWAY_Y      = 3'd4;

   typedef struct packed {
      logic [4:0] zones_across;
      logic [4:0] zones_down;
      logic [7:0] inner_padding;
      logic [7:0] leeway_x;
      logic [7:0] leeway_y;
   } cfg_type;

   typedef struct packed {
      logic signed [15:0] point_x;
      logic signed [15:0] point_y;
      logic signed [15:0] area_x;
      logic signed [15:0] area_y;
      logic [14:0]        area_width;
      logic [14:0]        area_height;
   } req_pay_type;

   typedef struct packed {
      logic capture;
      logic setup;
      logic div_step;
      logic walk_init;
      logic walk_step;
      logic store;
      logic ax;
      logic span;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic walk_done;
      logic hit;
   } status_type;

endpackage

[design/gzs_ifs.sv]
interface gzs_req_if;
   import gzs_pkg::*;
   logic               valid;
   logic               ready;
   logic [1:0]         mode;
   logic signed [15:0] point_x;
   logic signed [15:0] point_y;
   logic signed [15:0] area_x;
   logic signed [15:0] area_y;
   logic [14:0]        area_width;
   logic [14:0]        area_height;
   modport source (output valid, mode, point_x, point_y, area_x, area_y, area_width,
                   area_height, input ready);
   modport sink (input valid, mode, point_x, point_y, area_x, area_y, area_width,
                 area_height, output ready);
endinterface

interface gzs_rsp_if;
   logic               valid;
   logic               ready;
   logic               active;
   logic               shown;
   logic               span_on;
   logic               commit;
   logic signed [15:0] box_left;
   logic signed [15:0] box_top;
   logic [14:0]        box_width;
   logic [14:0]        box_height;
   modport source (output valid, active, shown, span_on, commit, box_left, box_top,
                   box_width, box_height, input ready);
   modport sink (input valid, active, shown, span_on, commit, box_left, box_top,
                 box_width, box_height, output ready);
endinterface

interface gzs_csr_if;
   logic       valid;
   logic       ready;
   logic [2:0] index;
   logic [7:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

[design/grid_zone_snap_selector_core.sv]
// Zone grid selector: each request beat (begin, pointer motion, span toggle or end) yields
// exactly one response beat carrying the selection flags and the stored final box. Toggle,
// end and motion while idle go straight to the response stage. Begin and active motion run
// a pointer test over both axes: per axis a setup step, bit-serial division for the rounded
// zone pitch (17 shift steps and a done check), a walk init step and one step per zone, then
// a store step. One request is in flight at a time; a new request is taken while the
// previous response still waits to be picked up.
module grid_zone_snap_selector_core
   import gzs_pkg::*;
#(
   parameter int MAX_ZONES_ACROSS = MAX_ZONES_ACROSS_DEF,
   parameter int MAX_ZONES_DOWN   = MAX_ZONES_DOWN_DEF
) (
   input  logic      clock,
   input  logic      reset,
   gzs_req_if.sink   req_chan,
   gzs_rsp_if.source rsp_chan,
   gzs_csr_if.sink   csr_chan
);

   localparam int MAXZ = (MAX_ZONES_ACROSS > MAX_ZONES_DOWN) ? MAX_ZONES_ACROSS
                                                             : MAX_ZONES_DOWN;
   localparam int NW   = $clog2(MAXZ + 1);

   cfg_type     cfg_ff;
   req_pay_type req_pay;
   cmd_type     cmd;
   status_type  status;
   logic        out_load, slot_free;
   logic        active, shown, span_on, commit;
   logic signed [15:0] fin_left, fin_top;
   logic [14:0]        fin_width, fin_height;

   logic               rsp_valid_ff;
   logic               rsp_active_ff, rsp_shown_ff, rsp_span_ff, rsp_commit_ff;
   logic signed [15:0] rsp_left_ff, rsp_top_ff;
   logic [14:0]        rsp_width_ff, rsp_height_ff;

   // configuration registers
   assign csr_chan.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.zones_across  <= 5'd2;
         cfg_ff.zones_down    <= 5'd2;
         cfg_ff.inner_padding <= 8'd0;
         cfg_ff.leeway_x      <= 8'd0;
         cfg_ff.leeway_y      <= 8'd0;
      end else if (csr_chan.valid) begin
         case (csr_chan.index)
            REG_ZONES_ACROSS:  cfg_ff.zones_across  <= csr_chan.data[4:0];
            REG_ZONES_DOWN:    cfg_ff.zones_down    <= csr_chan.data[4:0];
            REG_INNER_PADDING: cfg_ff.inner_padding <= csr_chan.data;
            REG_LEEWAY_X:      cfg_ff.leeway_x      <= csr_chan.data;
            REG_LEEWAY_Y:      cfg_ff.leeway_y      <= csr_chan.data;
            default: begin
            end
         endcase
      end
   end

   // request payload
   assign req_pay.point_x     = req_chan.point_x;
   assign req_pay.point_y     = req_chan.point_y;
   assign req_pay.area_x      = req_chan.area_x;
   assign req_pay.area_y      = req_chan.area_y;
   assign req_pay.area_width  = req_chan.area_width;
   assign req_pay.area_height = req_chan.area_height;

   gzs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_mode  (req_chan.mode),
      .req_ready (req_chan.ready),
      .slot_free (slot_free),
      .out_load  (out_load),
      .status    (status),
      .cmd       (cmd),
      .active    (active),
      .shown     (shown),
      .span_on   (span_on),
      .commit    (commit)
   );

   gzs_datapath #(
      .MAX_ZONES_ACROSS (MAX_ZONES_ACROSS),
      .MAX_ZONES_DOWN   (MAX_ZONES_DOWN),
      .NW               (NW)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_pay    (req_pay),
      .cmd        (cmd),
      .status     (status),
      .fin_left   (fin_left),
      .fin_top    (fin_top),
      .fin_width  (fin_width),
      .fin_height (fin_height)
   );

   // response register
   assign slot_free = !rsp_valid_ff || rsp_chan.ready;
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_active_ff <= active;
         rsp_shown_ff  <= shown;
         rsp_span_ff   <= span_on;
         rsp_commit_ff <= commit;
         rsp_left_ff   <= fin_left;
         rsp_top_ff    <= fin_top;
         rsp_width_ff  <= fin_width;
         rsp_height_ff <= fin_height;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.active     = rsp_active_ff;
   assign rsp_chan.shown      = rsp_shown_ff;
   assign rsp_chan.span_on    = rsp_span_ff;
   assign rsp_chan.commit     = rsp_commit_ff;
   assign rsp_chan.box_left   = rsp_left_ff;
   assign rsp_chan.box_top    = rsp_top_ff;
   assign rsp_chan.box_width  = rsp_width_ff;
   assign rsp_chan.box_height = rsp_height_ff;

endmodule

[design/gzs_datapath.sv]
module gzs_datapath
   import gzs_pkg::*;
#(
   parameter int MAX_ZONES_ACROSS = MAX_ZONES_ACROSS_DEF,
   parameter int MAX_ZONES_DOWN   = MAX_ZONES_DOWN_DEF,
   parameter int NW               = 5
) (
   input  logic               clock,
   input  logic               reset,
   input  cfg_type            cfg,
   input  req_pay_type        req_pay,
   input  cmd_type            cmd,
   output status_type         status,
   output logic signed [15:0] fin_left,
   output logic signed [15:0] fin_top,
   output logic [14:0]        fin_width,
   output logic [14:0]        fin_height
);

   localparam int PW  = 8 + NW;                   // padding times zone index
   localparam int DFW = ((PW > 15) ? PW : 15) + 2; // signed usable length
   localparam int DW  = NW + 1;                   // divisor 2n
   localparam int QW  = 17;                       // dividend 2*usable
   localparam int CW  = $clog2(QW + 1);
   localparam int EW  = 22;                       // exact edge values

   // captured item
   req_pay_type pay_ff;

   // divider and walk registers
   logic [14:0]          usable_in;
   logic [NW-1:0]        n_ff;
   logic [DW-1:0]        dvs_ff;
   logic [QW-1:0]        q_ff, q_in;
   logic [DW-1:0]        rem_ff, rem_in;
   logic [CW-1:0]        div_cnt_ff;
   logic [QW-1:0]        a_ff, a_in;
   logic [DW-1:0]        r_ff, r_in;
   logic [PW-1:0]        pad_acc_ff;
   logic [NW-1:0]        idx_ff;
   logic                 any_ff [2];
   logic signed [EW-1:0] lo_ff [2];
   logic signed [EW-1:0] hi_ff [2];

   // boxes
   logic signed [15:0] anc_left_ff, anc_top_ff, fin_left_ff, fin_top_ff;
   logic [14:0]        anc_width_ff, anc_height_ff, fin_width_ff, fin_height_ff;

   // axis selection
   logic signed [15:0] pt_sel, st_sel;
   logic [14:0]        len_sel;
   logic [4:0]         raw_sel;
   logic [7:0]         lee_sel;
   logic [NW-1:0]      n_sel;

   logic [PW-1:0]         pad_prod;
   logic signed [DFW-1:0] diff;
   logic [DW:0]           trial;
   logic [DW:0]           rs;
   logic                  wrap;
   logic signed [EW-1:0]  off, endv, pt_e, lee_e;
   logic [QW-1:0]         sz;
   logic                  zone_hit;

   function automatic logic signed [15:0] clamp_pos(input logic signed [EW-1:0] v);
      if (v < -EW'(32768))
         return 16'sh8000;
      else if (v > EW'(32767))
         return 16'sh7fff;
      else
         return v[15:0];
   endfunction

   function automatic logic [14:0] clamp_len(input logic signed [EW-1:0] v);
      if (v < 0)
         return 15'd0;
      else if (v > EW'(32767))
         return 15'h7fff;
      else
         return v[14:0];
   endfunction

   // per axis operands
   always_comb begin
      pt_sel  = cmd.ax ? pay_ff.point_y : pay_ff.point_x;
      st_sel  = cmd.ax ? pay_ff.area_y : pay_ff.area_x;
      len_sel = cmd.ax ? pay_ff.area_height : pay_ff.area_width;
      raw_sel = cmd.ax ? cfg.zones_down : cfg.zones_across;
      lee_sel = cmd.ax ? cfg.leeway_y : cfg.leeway_x;
      if (raw_sel == 5'd0)
         n_sel = NW'(1);
      else if (cmd.ax && (int'(raw_sel) > MAX_ZONES_DOWN))
         n_sel = NW'(MAX_ZONES_DOWN);
      else if (!cmd.ax && (int'(raw_sel) > MAX_ZONES_ACROSS))
         n_sel = NW'(MAX_ZONES_ACROSS);
      else
         n_sel = NW'(raw_sel);
   end

   // usable length, clamped at zero
   always_comb begin
      pad_prod  = PW'(cfg.inner_padding) * PW'(n_sel - NW'(1));
      diff      = $signed(DFW'(len_sel)) - $signed(DFW'(pad_prod));
      usable_in = (diff < 0) ? 15'd0 : diff[14:0];
   end

   // restoring divider step
   always_comb begin
      trial = {rem_ff, q_ff[QW-1]};
      if (trial >= (DW+1)'(dvs_ff)) begin
         rem_in = DW'(trial - (DW+1)'(dvs_ff));
         q_in   = {q_ff[QW-2:0], 1'b1};
      end else begin
         rem_in = trial[DW-1:0];
         q_in   = {q_ff[QW-2:0], 1'b0};
      end
   end

   // next zone edge from running quotient and remainder
   always_comb begin
      rs   = (DW+1)'(r_ff) + (DW+1)'(rem_ff);
      wrap = rs >= (DW+1)'(dvs_ff);
      r_in = wrap ? DW'(rs - (DW+1)'(dvs_ff)) : rs[DW-1:0];
      a_in = a_ff + q_ff + QW'(wrap);
   end

   // zone hit test
   always_comb begin
      sz       = a_in - a_ff;
      off      = EW'(st_sel) + $signed(EW'(pad_acc_ff)) + $signed(EW'(a_ff));
      endv     = off + $signed(EW'(sz));
      pt_e     = EW'(pt_sel);
      lee_e    = $signed(EW'(lee_sel));
      zone_hit = ((sz != '0) || (lee_sel != 8'd0)) && (pt_e >= off - lee_e) &&
                 (pt_e < endv + lee_e);
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         pay_ff <= req_pay;
      end
      // axis setup
      if (cmd.setup) begin
         n_ff       <= n_sel;
         dvs_ff     <= {n_sel, 1'b0};
         q_ff       <= {usable_in, 2'b0} >> 1;
         rem_ff     <= '0;
         div_cnt_ff <= CW'(QW);
      end
      if (cmd.div_step) begin
         q_ff       <= q_in;
         rem_ff     <= rem_in;
         div_cnt_ff <= div_cnt_ff - CW'(1);
      end
      // walk start
      if (cmd.walk_init) begin
         a_ff          <= '0;
         r_ff          <= DW'(n_ff);
         pad_acc_ff    <= '0;
         idx_ff        <= '0;
         any_ff[cmd.ax] <= 1'b0;
      end
      // one zone per cycle
      if (cmd.walk_step) begin
         a_ff       <= a_in;
         r_ff       <= r_in;
         pad_acc_ff <= pad_acc_ff + PW'(cfg.inner_padding);
         idx_ff     <= idx_ff + NW'(1);
         if (zone_hit) begin
            if (!any_ff[cmd.ax]) begin
               lo_ff[cmd.ax] <= off;
            end
            hi_ff[cmd.ax]  <= endv;
            any_ff[cmd.ax] <= 1'b1;
         end
      end
   end

   // box update
   logic signed [EW-1:0] al, at, ar, ab, nl, nt, nr, nb;
   always_comb begin
      al = EW'(anc_left_ff);
      at = EW'(anc_top_ff);
      ar = al + $signed(EW'(anc_width_ff));
      ab = at + $signed(EW'(anc_height_ff));
      nl = lo_ff[0];
      nt = lo_ff[1];
      nr = hi_ff[0];
      nb = hi_ff[1];
      if (cmd.span) begin
         nl = (al < lo_ff[0]) ? al : lo_ff[0];
         nt = (at < lo_ff[1]) ? at : lo_ff[1];
         nr = (ar > hi_ff[0]) ? ar : hi_ff[0];
         nb = (ab > hi_ff[1]) ? ab : hi_ff[1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         anc_left_ff   <= '0;
         anc_top_ff    <= '0;
         anc_width_ff  <= '0;
         anc_height_ff <= '0;
         fin_left_ff   <= '0;
         fin_top_ff    <= '0;
         fin_width_ff  <= '0;
         fin_height_ff <= '0;
      end else if (cmd.store && status.hit) begin
         fin_left_ff   <= clamp_pos(nl);
         fin_top_ff    <= clamp_pos(nt);
         fin_width_ff  <= clamp_len(nr - nl);
         fin_height_ff <= clamp_len(nb - nt);
         if (!cmd.span) begin
            anc_left_ff   <= clamp_pos(nl);
            anc_top_ff    <= clamp_pos(nt);
            anc_width_ff  <= clamp_len(nr - nl);
            anc_height_ff <= clamp_len(nb - nt);
         end
      end
   end

   // status
   assign status.div_done  = (div_cnt_ff == '0);
   assign status.walk_done = (idx_ff == n_ff - NW'(1));
   assign status.hit       = any_ff[0] && any_ff[1];

   assign fin_left   = fin_left_ff;
   assign fin_top    = fin_top_ff;
   assign fin_width  = fin_width_ff;
   assign fin_height = fin_height_ff;

   // divider must be done before zones are walked
   a_walk_after_div: assert property (@(posedge clock) disable iff (reset)
      cmd.walk_step |-> div_cnt_ff == '0)
      else $error("zone walk started before division finished");

   // running remainder stays below the divisor
   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      cmd.walk_step |-> r_ff < dvs_ff)
      else $error("running remainder out of range");

   // zone edges never move backward
   a_edge_monotone: assert property (@(posedge clock) disable iff (reset)
      cmd.walk_step |=> a_ff >= $past(a_ff))
      else $error("zone edge moved backward");

endmodule

[design/gzs_ctrl.sv]
module gzs_ctrl
   import gzs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic [1:0] req_mode,
   output logic       req_ready,
   input  logic       slot_free,
   output logic       out_load,
   input  status_type status,
   output cmd_type    cmd,
   output logic       active,
   output logic       shown,
   output logic       span_on,
   output logic       commit
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SETUP = 3'd1;
   localparam logic [2:0] S_DIV   = 3'd2;
   localparam logic [2:0] S_WINIT = 3'd3;
   localparam logic [2:0] S_WALK  = 3'd4;
   localparam logic [2:0] S_STORE = 3'd5;
   localparam logic [2:0] S_DONE  = 3'd6;

   logic [2:0] state_ff, state_in;
   logic       ax_ff, ax_in;
   logic       active_ff, active_in;
   logic       span_ff, span_in;
   logic       visible_ff, visible_in;
   logic       commit_ff, commit_in;
   logic       accept;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;

   // sequencer
   always_comb begin
      state_in   = state_ff;
      ax_in      = ax_ff;
      active_in  = active_ff;
      span_in    = span_ff;
      visible_in = visible_ff;
      commit_in  = commit_ff;
      cmd        = '0;
      cmd.ax     = ax_ff;
      cmd.span   = span_ff;
      out_load   = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.capture = 1'b1;
               commit_in   = 1'b0;
               ax_in       = 1'b0;
               state_in    = S_DONE;
               case (req_mode)
                  MODE_BEGIN: begin
                     span_in   = 1'b0;
                     active_in = 1'b1;
                     state_in  = S_SETUP;
                  end
                  MODE_MOTION: begin
                     if (active_ff) begin
                        state_in = S_SETUP;
                     end
                  end
                  MODE_TOGGLE: begin
                     if (active_ff) begin
                        span_in = !span_ff;
                     end
                  end
                  default: begin
                     if (active_ff) begin
                        commit_in  = span_ff;
                        visible_in = 1'b0;
                        active_in  = 1'b0;
                     end
                  end
               endcase
            end
         end
         S_SETUP: begin
            cmd.setup = 1'b1;
            state_in  = S_DIV;
         end
         S_DIV: begin
            if (status.div_done) begin
               state_in = S_WINIT;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         S_WINIT: begin
            cmd.walk_init = 1'b1;
            state_in      = S_WALK;
         end
         S_WALK: begin
            cmd.walk_step = 1'b1;
            if (status.walk_done) begin
               if (!ax_ff) begin
                  ax_in    = 1'b1;
                  state_in = S_SETUP;
               end else begin
                  state_in = S_STORE;
               end
            end
         end
         S_STORE: begin
            cmd.store  = 1'b1;
            visible_in = status.hit;
            state_in   = S_DONE;
         end
         S_DONE: begin
            if (slot_free) begin
               out_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         ax_ff      <= 1'b0;
         active_ff  <= 1'b0;
         span_ff    <= 1'b0;
         visible_ff <= 1'b0;
         commit_ff  <= 1'b0;
      end else begin
         state_ff   <= state_in;
         ax_ff      <= ax_in;
         active_ff  <= active_in;
         span_ff    <= span_in;
         visible_ff <= visible_in;
         commit_ff  <= commit_in;
      end
   end

   assign active  = active_ff;
   assign shown   = visible_ff;
   assign span_on = span_ff;
   assign commit  = commit_ff;

   // highlight only while a selection runs
   a_shown_active: assert property (@(posedge clock) disable iff (reset)
      visible_ff |-> active_ff)
      else $error("highlight shown while idle");

   // a commit always ends the selection
   a_commit_ends: assert property (@(posedge clock) disable iff (reset)
      commit_ff |-> !active_ff)
      else $error("commit while selection still active");

   // box store is followed by result delivery
   a_store_done: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_STORE |=> state_ff == S_DONE)
      else $error("store not followed by result");

endmodule

[bench/tb_grid_zone_snap_selector_core.sv]
`timescale 1ns / 100ps

module tb_grid_zone_snap_selector_core;
   import gzs_pkg::*;

   // beat contents seen from the bench
   typedef struct {
      logic [1:0]         mode;
      logic signed [15:0] px;
      logic signed [15:0] py;
      logic signed [15:0] ax;
      logic signed [15:0] ay;
      logic [14:0]        aw;
      logic [14:0]        ah;
   } sel_event_type;

   typedef struct {
      logic               active;
      logic               shown;
      logic               span_on;
      logic               commit;
      logic signed [15:0] left;
      logic signed [15:0] top;
      logic [14:0]        width;
      logic [14:0]        height;
   } sel_status_type;

   logic clock;
   logic reset;

   gzs_req_if req_chan ();
   gzs_rsp_if rsp_chan ();
   gzs_csr_if csr_chan ();

   grid_zone_snap_selector_core dut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan.sink),
      .rsp_chan(rsp_chan.source),
      .csr_chan(csr_chan.sink)
   );

   // clock
   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // shadow of the block's registers and state
   logic [4:0]  m_across, m_down;
   logic [7:0]  m_pad, m_lee_x, m_lee_y;
   bit          m_active, m_span, m_shown;
   longint      anchor_l, anchor_t, anchor_w, anchor_h;
   longint      final_l, final_t, final_w, final_h;

   sel_status_type expected_status[$];
   int          errors;
   int          beats_sent;
   int          beats_checked;
   int          commits_seen;
   int          hits_seen;
   longint      cycle_count = 0;
   bit          rsp_stall_on;

   function automatic longint clip(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic longint eff_count(logic [4:0] raw, int maxv);
      if (raw == 0) return 1;
      return raw > maxv ? maxv : raw;
   endfunction

   // one axis of the zone hit test, span of hit zones in lo..hi
   function automatic bit axis_hit(longint p, longint start, longint len, longint n,
                                   longint lee, output longint lo, output longint hi);
      longint usable, a, b, off, sz;
      bit     any;
      any = 0;
      lo = 0;
      hi = 0;
      usable = len - longint'(m_pad) * (n - 1);
      if (usable < 0) usable = 0;
      for (longint i = 0; i < n; i++) begin
         a = (2 * usable * i + n) / (2 * n);
         b = (2 * usable * (i + 1) + n) / (2 * n);
         off = start + longint'(m_pad) * i + a;
         sz = b - a;
         if (sz + 2 * lee > 0 && p >= off - lee && p < off + sz + lee) begin
            if (!any || off < lo) lo = off;
            if (!any || off + sz > hi) hi = off + sz;
            any = 1;
         end
      end
      return any;
   endfunction

   function automatic void pointer_hit(sel_event_type e);
      longint xl, xh, yl, yh, l, t, r, b;
      bit     hx, hy;
      hx = axis_hit(e.px, e.ax, e.aw, eff_count(m_across, MAX_ZONES_ACROSS_DEF),
                    m_lee_x, xl, xh);
      hy = axis_hit(e.py, e.ay, e.ah, eff_count(m_down, MAX_ZONES_DOWN_DEF),
                    m_lee_y, yl, yh);
      if (!(hx && hy)) begin
         m_shown = 0;
         return;
      end
      hits_seen++;
      if (m_span) begin
         l = anchor_l < xl ? anchor_l : xl;
         t = anchor_t < yl ? anchor_t : yl;
         r = anchor_l + anchor_w;
         b = anchor_t + anchor_h;
         r = r > xh ? r : xh;
         b = b > yh ? b : yh;
      end else begin
         l = xl; t = yl; r = xh; b = yh;
         anchor_l = clip(l, -32768, 32767);
         anchor_t = clip(t, -32768, 32767);
         anchor_w = clip(r - l, 0, 32767);
         anchor_h = clip(b - t, 0, 32767);
      end
      final_l = clip(l, -32768, 32767);
      final_t = clip(t, -32768, 32767);
      final_w = clip(r - l, 0, 32767);
      final_h = clip(b - t, 0, 32767);
      m_shown = 1;
   endfunction

   function automatic sel_status_type predict_status(sel_event_type e);
      sel_status_type s;
      bit          com;
      com = 0;
      case (e.mode)
         MODE_BEGIN: begin
            m_span = 0;
            m_active = 1;
            pointer_hit(e);
         end
         MODE_MOTION: begin
            if (m_active) pointer_hit(e);
         end
         MODE_TOGGLE: begin
            if (m_active) m_span = !m_span;
         end
         default: begin
            if (m_active) begin
               com = m_span;
               m_shown = 0;
               m_active = 0;
            end
         end
      endcase
      s.active = m_active;
      s.shown = m_shown;
      s.span_on = m_span;
      s.commit = com;
      s.left = final_l[15:0];
      s.top = final_t[15:0];
      s.width = final_w[14:0];
      s.height = final_h[14:0];
      return s;
   endfunction

   // cycle counter and timeout
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 3000000) begin
         $display("FAIL grid_zone_snap_selector_core");
         $finish;
      end
   end

   // response ready with random stalls
   always @(posedge clock) begin
      if (reset || !rsp_stall_on) begin
         rsp_chan.ready <= 1'b1;
      end else if ($urandom_range(0, 99) < 8) begin
         rsp_chan.ready <= 1'b0;
      end else if ($urandom_range(0, 99) < 40) begin
         rsp_chan.ready <= 1'b1;
      end
   end

   // response checker
   always @(posedge clock) begin
      sel_status_type exp_s;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_status.size() == 0) begin
            $error("response beat with nothing expected");
            errors++;
         end else begin
            exp_s = expected_status.pop_front();
            beats_checked++;
            if (rsp_chan.commit) commits_seen++;
            if (rsp_chan.active !== exp_s.active) begin
               $error("active exp %0d got %0d", exp_s.active, rsp_chan.active);
               errors++;
            end
            if (rsp_chan.shown !== exp_s.shown) begin
               $error("shown exp %0d got %0d", exp_s.shown, rsp_chan.shown);
               errors++;
            end
            if (rsp_chan.span_on !== exp_s.span_on) begin
               $error("span_on exp %0d got %0d", exp_s.span_on, rsp_chan.span_on);
               errors++;
            end
            if (rsp_chan.commit !== exp_s.commit) begin
               $error("commit exp %0d got %0d", exp_s.commit, rsp_chan.commit);
               errors++;
            end
            if (rsp_chan.box_left !== exp_s.left) begin
               $error("box_left exp %0d got %0d", exp_s.left, rsp_chan.box_left);
               errors++;
            end
            if (rsp_chan.box_top !== exp_s.top) begin
               $error("box_top exp %0d got %0d", exp_s.top, rsp_chan.box_top);
               errors++;
            end
            if (rsp_chan.box_width !== exp_s.width) begin
               $error("box_width exp %0d got %0d", exp_s.width, rsp_chan.box_width);
               errors++;
            end
            if (rsp_chan.box_height !== exp_s.height) begin
               $error("box_height exp %0d got %0d", exp_s.height, rsp_chan.box_height);
               errors++;
            end
         end
      end
   end

   task automatic idle_gap();
      int n;
      n = $urandom_range(0, 99) < 85 ? $urandom_range(0, 3) : $urandom_range(10, 60);
      repeat (n) @(posedge clock);
   endtask

   // send one request beat and record its expected response
   task automatic send_event(sel_event_type e, bit gaps = 1);
      if (gaps && $urandom_range(0, 3) == 0) idle_gap();
      req_chan.valid <= 1'b1;
      req_chan.mode <= e.mode;
      req_chan.point_x <= e.px;
      req_chan.point_y <= e.py;
      req_chan.area_x <= e.ax;
      req_chan.area_y <= e.ay;
      req_chan.area_width <= e.aw;
      req_chan.area_height <= e.ah;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      expected_status.push_back(predict_status(e));
      beats_sent++;
      req_chan.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain();
      while (expected_status.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [7:0] val);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data <= val;
      @(posedge clock);
      while (!csr_chan.ready) @(posedge clock);
      csr_chan.valid <= 1'b0;
      case (idx)
         REG_ZONES_ACROSS:  m_across = val[4:0];
         REG_ZONES_DOWN:    m_down = val[4:0];
         REG_INNER_PADDING: m_pad = val;
         REG_LEEWAY_X:      m_lee_x = val;
         REG_LEEWAY_Y:      m_lee_y = val;
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic set_grid(logic [4:0] na, logic [4:0] nd, logic [7:0] pad,
                           logic [7:0] lx, logic [7:0] ly);
      drain();
      write_reg(REG_ZONES_ACROSS, {3'b0, na});
      write_reg(REG_ZONES_DOWN, {3'b0, nd});
      write_reg(REG_INNER_PADDING, pad);
      write_reg(REG_LEEWAY_X, lx);
      write_reg(REG_LEEWAY_Y, ly);
   endtask

   function automatic sel_event_type make_event(logic [1:0] mode, int px, int py, int ax,
                                                int ay, int aw, int ah);
      sel_event_type e;
      e.mode = mode;
      e.px = 16'(px); e.py = 16'(py); e.ax = 16'(ax); e.ay = 16'(ay);
      e.aw = 15'(aw); e.ah = 15'(ah);
      return e;
   endfunction

   // random event, mostly inside or near the area
   function automatic sel_event_type random_event(logic [1:0] mode, bit wide);
      sel_event_type e;
      e.mode = mode;
      if (wide || $urandom_range(0, 9) == 0) begin
         e.ax = 16'($urandom); e.ay = 16'($urandom);
         e.aw = 15'($urandom); e.ah = 15'($urandom);
         e.px = 16'($urandom); e.py = 16'($urandom);
      end else begin
         e.ax = 16'(int'($urandom_range(0, 400)) - 200);
         e.ay = 16'(int'($urandom_range(0, 400)) - 200);
         e.aw = $urandom_range(0, 9) == 0 ? 15'($urandom_range(0, 20))
                                          : 15'($urandom_range(20, 2000));
         e.ah = $urandom_range(0, 9) == 0 ? 15'($urandom_range(0, 20))
                                          : 15'($urandom_range(20, 2000));
         e.px = 16'(int'(e.ax) + int'($urandom_range(0, int'(e.aw) + 80)) - 40);
         e.py = 16'(int'(e.ay) + int'($urandom_range(0, int'(e.ah) + 80)) - 40);
      end
      return e;
   endfunction

   // extremes of fields, every mode and the named corner cases
   task automatic test_directed();
      send_event(make_event(MODE_MOTION, 10, 10, 0, 0, 100, 100));
      send_event(make_event(MODE_TOGGLE, 10, 10, 0, 0, 100, 100));
      send_event(make_event(MODE_END, 10, 10, 0, 0, 100, 100));
      // stale anchor: span with no hit since begin
      send_event(make_event(MODE_BEGIN, 500, 500, 0, 0, 100, 100));
      send_event(make_event(MODE_TOGGLE, 0, 0, 0, 0, 0, 0));
      send_event(make_event(MODE_MOTION, 70, 20, 0, 0, 100, 100));
      send_event(make_event(MODE_END, 0, 0, 0, 0, 0, 0));
      // normal span selection with commit
      send_event(make_event(MODE_BEGIN, 10, 10, 0, 0, 101, 99));
      send_event(make_event(MODE_TOGGLE, 0, 0, 0, 0, 0, 0));
      send_event(make_event(MODE_MOTION, 90, 90, 0, 0, 101, 99));
      send_event(make_event(MODE_END, 0, 0, 0, 0, 0, 0));
      send_event(make_event(MODE_END, 0, 0, 0, 0, 0, 0));
      // saturation at the edges of the coordinate range
      send_event(make_event(MODE_BEGIN, 32767, 32767, 32767, 32767, 32767, 32767));
      send_event(make_event(MODE_BEGIN, -32768, -32768, -32768, -32768, 32767, 32767));
      send_event(make_event(MODE_TOGGLE, 0, 0, 0, 0, 0, 0));
      send_event(make_event(MODE_MOTION, 32766, 32766, 0, 0, 32767, 32767));
      send_event(make_event(MODE_END, -1, -1, -1, -1, 0, 0));
      send_event(make_event(MODE_BEGIN, 0, 0, 0, 0, 0, 0));
      send_event(make_event(MODE_END, 0, 0, 0, 0, 0, 0));
   endtask

   // well-formed selections with random content, plus noise
   task automatic test_random(int count);
      int n;
      int k;
      k = 0;
      while (k < count) begin
         if ($urandom_range(0, 9) < 8) begin
            send_event(random_event(MODE_BEGIN, 0)); k++;
            n = $urandom_range(0, 6);
            repeat (n) begin
               if ($urandom_range(0, 3) == 0) send_event(random_event(MODE_TOGGLE, 1));
               else send_event(random_event(MODE_MOTION, 0));
               k++;
            end
            if ($urandom_range(0, 9) != 0) begin
               send_event(random_event(MODE_END, 1)); k++;
            end
         end else begin
            send_event(random_event(2'($urandom_range(0, 3)), 1)); k++;
         end
      end
   endtask

   // back to back beats, with one full drain in the middle
   task automatic test_back_to_back();
      for (int i = 0; i < 30; i++) begin
         send_event(random_event(2'($urandom_range(0, 3)), 0), 0);
         if (i == 15) while (expected_status.size() != 0) @(posedge clock);
      end
   endtask

   initial begin
      errors = 0; beats_sent = 0; beats_checked = 0; commits_seen = 0; hits_seen = 0;
      rsp_stall_on = 0;
      m_across = 2; m_down = 2; m_pad = 0; m_lee_x = 0; m_lee_y = 0;
      m_active = 0; m_span = 0; m_shown = 0;
      anchor_l = 0; anchor_t = 0; anchor_w = 0; anchor_h = 0;
      final_l = 0; final_t = 0; final_w = 0; final_h = 0;
      reset <= 1'b1;
      req_chan.valid <= 1'b0;
      req_chan.mode <= MODE_BEGIN;
      req_chan.point_x <= '0; req_chan.point_y <= '0;
      req_chan.area_x <= '0; req_chan.area_y <= '0;
      req_chan.area_width <= '0; req_chan.area_height <= '0;
      csr_chan.valid <= 1'b0; csr_chan.index <= REG_ZONES_ACROSS; csr_chan.data <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset grid first, then several settings including the extremes
      test_directed();
      rsp_stall_on = 1;
      test_random(350);
      set_grid(16, 16, 255, 255, 255);
      test_directed();
      test_random(250);
      set_grid(1, 1, 0, 0, 0);
      test_random(200);
      set_grid(0, 31, 7, 3, 200);
      test_random(200);
      set_grid(17, 0, 1, 255, 0);
      test_random(200);
      for (int p = 0; p < 3; p++) begin
         set_grid(5'($urandom_range(1, 16)), 5'($urandom_range(1, 16)),
                  8'($urandom_range(0, 40)), 8'($urandom_range(0, 30)),
                  8'($urandom_range(0, 30)));
         test_random(200);
         test_back_to_back();
      end

      drain();
      $display("covered %0d beats, %0d checked, %0d pointer hits, %0d commits",
               beats_sent, beats_checked, hits_seen, commits_seen);
      $display("grid settings from 1x1 to 16x16 plus out of range counts, paddings 0..255");
      if (errors == 0) begin
         $display("PASS grid_zone_snap_selector_core");
      end else begin
         $display("FAIL grid_zone_snap_selector_core");
      end
      $finish;
   end

endmodule
